// ===== sv/ic3_pkg.sv =====
// Shared constants, types and helpers of the 3x3 convolution block.
`default_nettype none
package ic3_pkg;

    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int DEFAULT_CHANNELS  = 3;

    localparam int PIX_W      = 8;
    localparam int PIX_CH     = 3;
    localparam int PIXEL_W    = PIX_W * PIX_CH;
    localparam int TAP_W      = 12;
    localparam int NUM_TAPS   = 9;
    localparam int TAPS_W     = TAP_W * NUM_TAPS;
    localparam int PROD_W     = 20;
    localparam int LANE_SUM_W = 24;
    localparam int RES_W      = 25;
    localparam int OUT_X_W    = 10;
    localparam int OUT_Y_W    = 16;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 104;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    localparam int TAPS_LOW_W  = 60;
    localparam int TAPS_HIGH_W = 48;
    localparam int IMG_W_W     = 11;
    localparam int IMG_H_W     = 16;
    localparam int NCH_W       = 2;

    localparam logic [IMG_W_W-1:0] RESET_WIDTH    = 11'd640;
    localparam logic [IMG_H_W-1:0] RESET_HEIGHT   = 16'd480;
    localparam logic [NCH_W-1:0]   RESET_CHANNELS = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAPS_LOW  = 3'd0,
        CFG_TAPS_HIGH = 3'd1,
        CFG_WIDTH     = 3'd2,
        CFG_HEIGHT    = 3'd3,
        CFG_CHANNELS  = 3'd4,
        CFG_PRESERVE  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [OUT_X_W-1:0] x;
        logic [OUT_Y_W-1:0] y;
        logic               last;
        logic               frame;
    } res_meta_t;

    // Window row/column that a kernel offset lands on once clamped to the frame.
    // at_pos: result sits at the newest position; otherwise one behind it.
    function automatic logic [1:0] sel_idx(input logic at_pos, input logic [1:0] d,
                                           input logic ge1, input logic ge2);
        logic [1:0] idx;
        idx = 2'd2;
        if (!at_pos) begin
            case (d)
                2'd0:    idx = ge2 ? 2'd0 : 2'd1;
                2'd1:    idx = 2'd1;
                default: idx = 2'd2;
            endcase
        end else if (d == 2'd0) begin
            idx = ge1 ? 2'd1 : 2'd2;
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== sv/ic3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ic3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/ic3_lane.sv =====
// One channel lane: nine tap products, then their sum.
`default_nettype none
module ic3_lane (
    input  wire logic                                    clk,
    input  wire logic                                    en,
    input  wire logic [ic3_pkg::TAPS_W-1:0]              taps,
    input  wire logic [ic3_pkg::NUM_TAPS*ic3_pkg::PIX_W-1:0] pix,
    output logic signed [ic3_pkg::LANE_SUM_W-1:0]        sum
);

    logic signed [ic3_pkg::PROD_W-1:0]     prod_reg [ic3_pkg::NUM_TAPS];
    logic signed [ic3_pkg::PROD_W-1:0]     prod_next [ic3_pkg::NUM_TAPS];
    logic signed [ic3_pkg::LANE_SUM_W-1:0] sum_reg;
    logic signed [ic3_pkg::LANE_SUM_W-1:0] sum_next;

    always_comb
    begin
        for (int k = 0; k < ic3_pkg::NUM_TAPS; k++)
        begin
            prod_next[k] = ic3_pkg::PROD_W'($signed(taps[k*ic3_pkg::TAP_W +: ic3_pkg::TAP_W]))
                         * ic3_pkg::PROD_W'($signed({1'b0,
                                             pix[k*ic3_pkg::PIX_W +: ic3_pkg::PIX_W]}));
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < ic3_pkg::NUM_TAPS; k++)
        begin
            sum_next = sum_next + ic3_pkg::LANE_SUM_W'(prod_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule
`default_nettype wire

// ===== sv/ic3_merge.sv =====
// Combine the lane sums: per-channel results or one total over the channels in use.
`default_nettype none
module ic3_merge #(
    parameter int NLANE = 3
) (
    input  wire logic [NLANE*ic3_pkg::LANE_SUM_W-1:0] lane_sum,
    input  wire logic [ic3_pkg::NCH_W-1:0]            channels_in_use,
    input  wire logic                                 preserve,
    output logic [ic3_pkg::PIX_CH*ic3_pkg::RES_W-1:0] res
);

    logic [ic3_pkg::NCH_W-1:0]            nch;
    logic signed [ic3_pkg::LANE_SUM_W-1:0] ls;
    logic signed [ic3_pkg::RES_W-1:0]      ext;
    logic signed [ic3_pkg::RES_W-1:0]      total;

    assign nch = (channels_in_use == '0) ? ic3_pkg::NCH_W'(1) : channels_in_use;

    always_comb
    begin
        total = '0;
        res   = '0;
        ls    = '0;
        ext   = '0;
        for (int k = 0; k < NLANE; k++)
        begin
            ls  = $signed(lane_sum[k*ic3_pkg::LANE_SUM_W +: ic3_pkg::LANE_SUM_W]);
            ext = ic3_pkg::RES_W'(ls);
            if (k < int'(nch))
            begin
                total = total + ext;
                if (preserve)
                begin
                    res[k*ic3_pkg::RES_W +: ic3_pkg::RES_W] = ext;
                end
            end
        end
        if (!preserve)
        begin
            res[ic3_pkg::RES_W-1:0] = total;
        end
    end

endmodule
`default_nettype wire

// ===== sv/image_convolution_3x3_top.sv =====
// Top level of the streaming 3x3 convolution with clamp-to-edge border.
`default_nettype none
// Pixels enter in raster order, one per cycle. Each pixel gives at most one
// result on ordinary rows (none on the first row and first column, two at the
// end of a row) and up to four on the last row, so the result port sets the
// sustained rate: one result per cycle while m_tready holds, and an input
// stalls while its results leave. Each stage is registered. The two line
// stores sit in one RAM, one read and one write a cycle, holding both older
// rows of a column in one word; its contents are undefined after reset and
// need no clearing. Channel lanes run side by side with one multiplier per
// tap; results are exact signed Q25.0, nothing is rounded.
module image_convolution_3x3_top #(
    parameter int MAX_WIDTH = ic3_pkg::DEFAULT_MAX_WIDTH,
    parameter int CHANNELS  = ic3_pkg::DEFAULT_CHANNELS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // sample0, sample1, sample2
    input  wire logic [ic3_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_x, out_y, result0, result1, result2, zero pad
    output logic [ic3_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tlast,
    // frame_done
    output logic                                 m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ic3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ic3_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int NLANE = (CHANNELS < ic3_pkg::PIX_CH) ? CHANNELS : ic3_pkg::PIX_CH;
    localparam int WCW   = ((XW + 1 > ic3_pkg::IMG_W_W) ? XW + 1 : ic3_pkg::IMG_W_W) + 1;
    localparam int HCW   = ic3_pkg::IMG_H_W + 1;
    localparam int PW    = ic3_pkg::PIXEL_W;
    localparam int RESW  = ic3_pkg::PIX_CH * ic3_pkg::RES_W;

    // configuration
    logic [ic3_pkg::TAPS_LOW_W-1:0]  taps_low_reg;
    logic [ic3_pkg::TAPS_HIGH_W-1:0] taps_high_reg;
    logic [ic3_pkg::IMG_W_W-1:0]     width_reg;
    logic [ic3_pkg::IMG_H_W-1:0]     height_reg;
    logic [ic3_pkg::NCH_W-1:0]       nch_reg;
    logic                            preserve_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_low_reg  <= '0;
            taps_high_reg <= '0;
            width_reg     <= ic3_pkg::RESET_WIDTH;
            height_reg    <= ic3_pkg::RESET_HEIGHT;
            nch_reg       <= ic3_pkg::RESET_CHANNELS;
            preserve_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ic3_pkg::cfg_index_t'(cfg_index))
                ic3_pkg::CFG_TAPS_LOW:  taps_low_reg  <= cfg_data[ic3_pkg::TAPS_LOW_W-1:0];
                ic3_pkg::CFG_TAPS_HIGH: taps_high_reg <= cfg_data[ic3_pkg::TAPS_HIGH_W-1:0];
                ic3_pkg::CFG_WIDTH:     width_reg     <= cfg_data[ic3_pkg::IMG_W_W-1:0];
                ic3_pkg::CFG_HEIGHT:    height_reg    <= cfg_data[ic3_pkg::IMG_H_W-1:0];
                ic3_pkg::CFG_CHANNELS:  nch_reg       <= cfg_data[ic3_pkg::NCH_W-1:0];
                ic3_pkg::CFG_PRESERVE:  preserve_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // frame position
    logic [XW-1:0]               x_reg;
    logic [XW-1:0]               x_next;
    logic [ic3_pkg::IMG_H_W-1:0] y_reg;
    logic [ic3_pkg::IMG_H_W-1:0] y_next;
    logic [WCW-1:0]              w_eff;
    logic [HCW-1:0]              h_eff;
    logic                        eol;
    logic                        lastrow;
    logic                        in_acc;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WCW'(1);
        else if (WCW'(width_reg) > WCW'(MAX_WIDTH))
            w_eff = WCW'(MAX_WIDTH);
        else
            w_eff = WCW'(width_reg);
        h_eff = (height_reg == '0) ? HCW'(1) : HCW'(height_reg);
    end

    assign eol     = (WCW'(x_reg) + WCW'(1)) >= w_eff;
    assign lastrow = (HCW'(y_reg) + HCW'(1)) >= h_eff;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (in_acc)
        begin
            if (eol)
            begin
                x_next = '0;
                y_next = lastrow ? '0 : y_reg + 1'b1;
            end
            else
            begin
                x_next = x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    // stage 1: line-store read in flight
    logic                        s1_valid_reg;
    logic [PW-1:0]               s1_cur_reg;
    logic [XW-1:0]               s1_x_reg;
    logic [ic3_pkg::IMG_H_W-1:0] s1_y_reg;
    logic                        s1_eol_reg;
    logic                        s1_last_reg;
    logic                        s1_adv;

    logic [2*PW-1:0] ram_q;
    logic [2*PW-1:0] rd;
    logic [2*PW-1:0] ram_wdata;
    logic            byp_reg;
    logic [2*PW-1:0] byp_data_reg;

    assign s_tready  = !s1_valid_reg || s1_adv;
    assign in_acc    = s_tvalid && s_tready;
    assign ram_wdata = {s1_cur_reg, rd[2*PW-1:PW]};
    assign rd        = byp_reg ? byp_data_reg : ram_q;

    ic3_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_x_reg),
        .wdata (ram_wdata),
        .re    (in_acc),
        .raddr (x_reg),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            // forward a write to the column being read in the same cycle
            if (in_acc)
                byp_reg <= s1_adv && (s1_x_reg == x_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cur_reg   <= s_tdata[PW-1:0];
            s1_x_reg     <= x_reg;
            s1_y_reg     <= y_reg;
            s1_eol_reg   <= eol;
            s1_last_reg  <= lastrow;
            byp_data_reg <= ram_wdata;
        end
    end

    // stage 2: window and result sequencing
    logic [PW-1:0]               win_reg [3][3];
    logic                        s2_valid_reg;
    logic                        s2_empty_reg;
    logic [XW-1:0]               s2_x_reg;
    logic [ic3_pkg::IMG_H_W-1:0] s2_y_reg;
    logic                        s2_eol_reg;
    logic                        s2_last_reg;
    logic                        rs_reg;
    logic                        cs_reg;
    logic                        pipe_en;
    logic                        emit;
    logic                        s2_end;
    logic                        s2_done;

    assign pipe_en = !m_tvalid || m_tready;
    assign emit    = s2_valid_reg && !s2_empty_reg && pipe_en;
    assign s2_end  = (rs_reg == s2_last_reg) && (cs_reg == s2_eol_reg);
    assign s2_done = s2_valid_reg && (s2_empty_reg || (emit && s2_end));
    assign s1_adv  = s1_valid_reg && (!s2_valid_reg || s2_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            rs_reg       <= 1'b0;
            cs_reg       <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= 1'b1;
            rs_reg       <= (s1_y_reg == '0);
            cs_reg       <= (s1_x_reg == '0);
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= rd[PW-1:0];
            win_reg[1][2] <= rd[2*PW-1:PW];
            win_reg[2][2] <= s1_cur_reg;
        end
        else
        begin
            if (s2_done)
                s2_valid_reg <= 1'b0;
            else if (emit)
            begin
                // advance along the row, then wrap to the next output row
                if (cs_reg == s2_eol_reg)
                begin
                    cs_reg <= (s2_x_reg == '0);
                    rs_reg <= 1'b1;
                end
                else
                    cs_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_eol_reg   <= s1_eol_reg;
            s2_last_reg  <= s1_last_reg;
            s2_empty_reg <= !(((s1_y_reg != '0) || s1_last_reg) &&
                              ((s1_x_reg != '0) || s1_eol_reg));
        end
    end

    logic [PW-1:0]       sel_pix [ic3_pkg::NUM_TAPS];
    ic3_pkg::res_meta_t  sel_meta;
    logic [1:0]          pr;
    logic [1:0]          pc;

    always_comb
    begin
        pr = '0;
        pc = '0;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                pr = ic3_pkg::sel_idx(rs_reg, 2'(dr), s2_y_reg >= 1, s2_y_reg >= 2);
                pc = ic3_pkg::sel_idx(cs_reg, 2'(dc), s2_x_reg >= 1, s2_x_reg >= 2);
                sel_pix[dr*3+dc] = win_reg[pr][pc];
            end
        end
        sel_meta.x     = ic3_pkg::OUT_X_W'(cs_reg ? s2_x_reg : s2_x_reg - 1'b1);
        sel_meta.y     = rs_reg ? s2_y_reg : s2_y_reg - 1'b1;
        sel_meta.last  = s2_end;
        sel_meta.frame = s2_eol_reg && s2_last_reg && rs_reg && cs_reg;
    end

    // stage 3 to output: lanes and merge
    logic                s3_valid_reg;
    logic                p1_valid_reg;
    logic                p2_valid_reg;
    logic [PW-1:0]       s3_pix_reg [ic3_pkg::NUM_TAPS];
    ic3_pkg::res_meta_t  s3_meta_reg;
    ic3_pkg::res_meta_t  p1_meta_reg;
    ic3_pkg::res_meta_t  p2_meta_reg;
    ic3_pkg::res_meta_t  out_meta_reg;
    logic [RESW-1:0]     out_res_reg;
    logic [RESW-1:0]     merged;
    logic [NLANE*ic3_pkg::LANE_SUM_W-1:0] lane_sum;
    logic [ic3_pkg::TAPS_W-1:0]           taps;

    assign taps = {taps_high_reg, taps_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_tvalid     <= 1'b0;
        end
        else if (pipe_en)
        begin
            s3_valid_reg <= emit;
            p1_valid_reg <= s3_valid_reg;
            p2_valid_reg <= p1_valid_reg;
            m_tvalid     <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s3_pix_reg   <= sel_pix;
            s3_meta_reg  <= sel_meta;
            p1_meta_reg  <= s3_meta_reg;
            p2_meta_reg  <= p1_meta_reg;
            out_meta_reg <= p2_meta_reg;
            out_res_reg  <= merged;
        end
    end

    for (genvar l = 0; l < NLANE; l++)
    begin : g_lane
        logic [ic3_pkg::NUM_TAPS*ic3_pkg::PIX_W-1:0] lane_pix;

        always_comb
        begin
            for (int k = 0; k < ic3_pkg::NUM_TAPS; k++)
                lane_pix[k*ic3_pkg::PIX_W +: ic3_pkg::PIX_W] =
                    s3_pix_reg[k][l*ic3_pkg::PIX_W +: ic3_pkg::PIX_W];
        end

        ic3_lane u_lane (
            .clk  (clk),
            .en   (pipe_en),
            .taps (taps),
            .pix  (lane_pix),
            .sum  (lane_sum[l*ic3_pkg::LANE_SUM_W +: ic3_pkg::LANE_SUM_W])
        );
    end

    ic3_merge #(
        .NLANE (NLANE)
    ) u_merge (
        .lane_sum        (lane_sum),
        .channels_in_use (nch_reg),
        .preserve        (preserve_reg),
        .res             (merged)
    );

    assign m_tdata = {{(ic3_pkg::M_TDATA_W - RESW - ic3_pkg::OUT_Y_W - ic3_pkg::OUT_X_W){1'b0}},
                      out_res_reg, out_meta_reg.y, out_meta_reg.x};
    assign m_tlast = out_meta_reg.last;
    assign m_tuser = out_meta_reg.frame;

    a_frame_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end not marked as last of run");

    a_emit_enters_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> s3_valid_reg)
        else $error("emitted result did not enter the lanes");

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s2_valid_reg))
        else $error("input stalled with free stage");

endmodule
`default_nettype wire
